/* rtl/bfr_pkg.sv */
// ============================================================================
// bfr_pkg
// Shared constants, codes and types of the bitstream field reader.
// ============================================================================
package bfr_pkg;

    localparam int DEF_MAX_WORDS  = 256;
    localparam int MAX_READ_BYTES = 32;
    localparam int RESULT_LIMIT   = 32;
    localparam int BYTE_LIMIT     = (MAX_READ_BYTES < RESULT_LIMIT) ? MAX_READ_BYTES
                                                                    : RESULT_LIMIT;
    localparam int WORD_BITS      = 32;
    localparam int BYTE_BITS      = 8;
    localparam int BYTES_PER_WORD = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CMD_W   = 3;
    localparam int COUNT_W = 6;
    localparam int LEN_W   = 11;
    localparam int BITS_W  = 14;
    localparam int STAT_W  = 2;
    localparam int WORDS_W = $clog2(BYTE_LIMIT / BYTES_PER_WORD + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART    = 3'd0,
        CMD_LOAD       = 3'd1,
        CMD_READ_BITS  = 3'd2,
        CMD_ALIGN      = 3'd3,
        CMD_READ_BYTES = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_RESTART,
        OP_LOAD,
        OP_BITS,
        OP_ALIGN,
        OP_BYTES,
        OP_EMPTY,
        OP_REFUSE
    } op_kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FAULT = 2'd1,
        ST_PAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_WAIT,
        BK_WORD
    } back_state_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [COUNT_W-1:0]     nbits;
        logic [WORD_BITS-1:0]   word;
        logic [1:0]             head;
        logic [WORDS_W-1:0]     words;
        logic [COUNT_W-1:0]     nbytes;
    } op_t;

endpackage

/* rtl/bfr_front.sv */
// ============================================================================
// bfr_front
// Accepts command transactions, checks them against a shadow of the read
// position and load count, and queues a fully classified operation.
// ============================================================================
module bfr_front #(
    parameter int MAX_WORDS = bfr_pkg::DEF_MAX_WORDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [bfr_pkg::LEN_W-1:0]     cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [bfr_pkg::CMD_W-1:0]     cmd,
    input  logic [bfr_pkg::COUNT_W-1:0]   field_bits,
    input  logic [bfr_pkg::COUNT_W-1:0]   byte_count,
    input  logic [bfr_pkg::WORD_BITS-1:0] load_word,
    input  logic                          queue_full,
    output logic                          push,
    output bfr_pkg::op_t                  push_op,
    output logic [bfr_pkg::BITS_W-1:0]    msg_bits
);
    import bfr_pkg::*;

    localparam int PTR_W = $clog2(MAX_WORDS + 1);

    logic [LEN_W-1:0]   msg_bytes_reg;
    logic [BITS_W-1:0]  total_reg;
    logic [BITS_W-1:0]  total_next;
    logic [PTR_W-1:0]   loaded_reg;
    logic [PTR_W-1:0]   loaded_next;

    logic [2:0]         rem_bits;
    logic [3:0]         pad_bits;
    logic [1:0]         head_raw;
    logic [1:0]         head;
    logic [COUNT_W-1:0] after_head;
    logic [8:0]         byte_bits;
    logic [BITS_W:0]    limit;
    logic [BITS_W:0]    end_bits;
    logic [BITS_W:0]    end_pad;
    logic [BITS_W:0]    end_bytes;
    logic               count_ok;

    assign msg_bits  = {msg_bytes_reg, 3'b000};
    assign cmd_ready = !queue_full;
    assign push      = cmd_valid && !queue_full;

    always_comb
    begin
        limit      = {1'b0, msg_bits};
        end_bits   = {1'b0, total_reg} + (BITS_W + 1)'(field_bits);
        rem_bits   = total_reg[2:0];
        pad_bits   = 4'd8 - {1'b0, rem_bits};
        end_pad    = {1'b0, total_reg} + (BITS_W + 1)'(pad_bits);
        byte_bits  = {byte_count, 3'b000};
        end_bytes  = {1'b0, total_reg} + (BITS_W + 1)'(byte_bits);
        head_raw   = 2'd0 - total_reg[4:3];
        head       = ({4'b0, head_raw} > byte_count) ? byte_count[1:0] : head_raw;
        after_head = byte_count - {4'b0, head};
        count_ok   = (byte_count != '0) && (byte_count <= COUNT_W'(BYTE_LIMIT));
    end

    always_comb
    begin
        push_op.kind   = OP_REFUSE;
        push_op.nbits  = field_bits;
        push_op.word   = load_word;
        push_op.head   = head;
        push_op.words  = WORDS_W'(after_head[COUNT_W-1:2]);
        push_op.nbytes = byte_count;
        total_next     = total_reg;
        loaded_next    = loaded_reg;
        case (cmd)
            CMD_RESTART:
            begin
                push_op.kind = OP_RESTART;
                total_next   = '0;
                loaded_next  = '0;
            end
            CMD_LOAD:
            begin
                if (loaded_reg < PTR_W'(MAX_WORDS))
                begin
                    push_op.kind = OP_LOAD;
                    loaded_next  = loaded_reg + 1'b1;
                end
            end
            CMD_READ_BITS:
            begin
                if ((field_bits != '0) && (field_bits <= COUNT_W'(WORD_BITS))
                    && (end_bits <= limit))
                begin
                    push_op.kind = OP_BITS;
                    total_next   = end_bits[BITS_W-1:0];
                end
            end
            CMD_ALIGN:
            begin
                if (rem_bits == 3'd0)
                begin
                    push_op.kind = OP_EMPTY;
                end
                else if (end_pad <= limit)
                begin
                    push_op.kind  = OP_ALIGN;
                    push_op.nbits = COUNT_W'(pad_bits);
                    total_next    = end_pad[BITS_W-1:0];
                end
            end
            CMD_READ_BYTES:
            begin
                if (count_ok && (rem_bits == 3'd0) && (end_bytes <= limit))
                begin
                    push_op.kind = OP_BYTES;
                    total_next   = end_bytes[BITS_W-1:0];
                end
            end
            default:
            begin
                push_op.kind = OP_REFUSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_bytes_reg <= '0;
            total_reg     <= '0;
            loaded_reg    <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                msg_bytes_reg <= cfg_wdata;
            end
            if (push)
            begin
                total_reg  <= total_next;
                loaded_reg <= loaded_next;
            end
        end
    end

endmodule

/* rtl/bfr_queue.sv */
// ============================================================================
// bfr_queue
// Short first-in first-out queue of classified operations between the
// front and the back.
// ============================================================================
module bfr_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bfr_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output bfr_pkg::op_t pop_op
);
    import bfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/bfr_back.sv */
// ============================================================================
// bfr_back
// Carries out queued operations: word store, 64-bit scratch, read position
// and the registered result stage.
// ============================================================================
module bfr_back #(
    parameter int MAX_WORDS = bfr_pkg::DEF_MAX_WORDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfr_pkg::BITS_W-1:0]    msg_bits,
    input  logic                          q_not_empty,
    input  bfr_pkg::op_t                  q_op,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [bfr_pkg::WORD_BITS-1:0] value,
    output logic [bfr_pkg::STAT_W-1:0]    status,
    output logic                          last,
    output logic [bfr_pkg::BITS_W-1:0]    bits_consumed,
    output logic [bfr_pkg::BITS_W-1:0]    bits_left
);
    import bfr_pkg::*;

    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PTR_W  = $clog2(MAX_WORDS + 1);

    logic [WORD_BITS-1:0] mem [MAX_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;

    back_state_t          state_reg;
    back_state_t          state_next;
    op_t                  op_reg;
    op_t                  op_next;
    logic [1:0]           head_reg;
    logic [1:0]           head_next;
    logic [WORDS_W-1:0]   words_reg;
    logic [WORDS_W-1:0]   words_next;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    logic [PTR_W-1:0]     load_ptr_reg;
    logic [PTR_W-1:0]     load_ptr_next;
    logic [PTR_W-1:0]     read_ptr_reg;
    logic [PTR_W-1:0]     read_ptr_next;
    logic                 beyond_reg;
    logic                 beyond_next;
    logic [63:0]          scratch_reg;
    logic [63:0]          scratch_next;
    logic [5:0]           fill_reg;
    logic [5:0]           fill_next;
    logic [BITS_W-1:0]    total_reg;
    logic [BITS_W-1:0]    total_next;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic [WORD_BITS-1:0] value_reg;
    logic [WORD_BITS-1:0] value_next;
    status_t              status_reg;
    status_t              status_next;
    logic                 last_reg;
    logic                 last_next;
    logic [BITS_W-1:0]    consumed_reg;
    logic [BITS_W-1:0]    consumed_next;
    logic [BITS_W-1:0]    left_reg;
    logic [BITS_W-1:0]    left_next;

    logic                 slot_free;
    logic                 in_words;
    logic                 need_fetch;
    logic                 use_fetch;
    logic                 emit;
    logic                 emit_last;
    status_t              emit_status;
    logic [WORD_BITS-1:0] emit_value;
    logic [COUNT_W-1:0]   n_take;
    logic [WORD_BITS-1:0] fetched;
    logic [63:0]          merged;
    logic [WORD_BITS-1:0] take_value;
    logic [63:0]          take_scratch;
    logic [5:0]           take_fill;
    logic [BITS_W-1:0]    take_total;
    logic [4:0]           byte_shift;
    logic [7:0]           word_byte;

    assign res_valid     = res_valid_reg;
    assign value         = value_reg;
    assign status        = status_reg;
    assign last          = last_reg;
    assign bits_consumed = consumed_reg;
    assign bits_left     = left_reg;

    always_comb
    begin
        slot_free    = !res_valid_reg || res_ready;
        n_take       = (op_reg.kind == OP_BYTES) ? COUNT_W'(BYTE_BITS) : op_reg.nbits;
        in_words     = (op_reg.kind == OP_BYTES) && (head_reg == 2'd0) && (words_reg != '0);
        need_fetch   = (fill_reg < n_take);
        use_fetch    = (state_reg == BK_WAIT);
        fetched      = beyond_reg ? '0 : rd_data_reg;
        merged       = scratch_reg | (use_fetch ? ({32'b0, fetched} << fill_reg) : 64'b0);
        take_value   = merged[WORD_BITS-1:0] & ~({WORD_BITS{1'b1}} << n_take);
        take_scratch = merged >> n_take;
        take_fill    = 6'(7'(fill_reg) + (use_fetch ? 7'd32 : 7'd0) - 7'(n_take));
        take_total   = total_reg + BITS_W'(n_take);
        byte_shift   = {~idx_reg, 3'b000};
        word_byte    = 8'(fetched >> byte_shift);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (op_reg.kind)
                    OP_BITS, OP_ALIGN:
                    begin
                        if (need_fetch)
                        begin
                            state_next = BK_WAIT;
                        end
                        else if (slot_free)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    OP_BYTES:
                    begin
                        if (in_words)
                        begin
                            state_next = BK_WORD;
                        end
                        else if (need_fetch)
                        begin
                            state_next = BK_WAIT;
                        end
                        else if (slot_free)
                        begin
                            state_next = (rem_reg == COUNT_W'(1)) ? BK_IDLE : BK_EXEC;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                endcase
            end
            BK_WAIT:
            begin
                if (slot_free)
                begin
                    state_next = ((op_reg.kind == OP_BYTES) && (rem_reg != COUNT_W'(1)))
                                 ? BK_EXEC : BK_IDLE;
                end
            end
            BK_WORD:
            begin
                if (slot_free && (idx_reg == 2'd3))
                begin
                    state_next = (rem_reg == COUNT_W'(1)) ? BK_IDLE : BK_EXEC;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        emit           = 1'b0;
        emit_value     = '0;
        emit_status    = ST_OK;
        emit_last      = 1'b1;
        op_next        = op_reg;
        head_next      = head_reg;
        words_next     = words_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        load_ptr_next  = load_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        beyond_next    = beyond_reg;
        scratch_next   = scratch_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    head_next  = q_op.head;
                    words_next = q_op.words;
                    rem_next   = q_op.nbytes;
                    idx_next   = 2'd0;
                end
            end
            BK_EXEC:
            begin
                case (op_reg.kind)
                    OP_RESTART:
                    begin
                        if (slot_free)
                        begin
                            emit          = 1'b1;
                            load_ptr_next = '0;
                            read_ptr_next = '0;
                            scratch_next  = '0;
                            fill_next     = '0;
                            total_next    = '0;
                        end
                    end
                    OP_LOAD:
                    begin
                        if (slot_free)
                        begin
                            emit          = 1'b1;
                            mem_we        = 1'b1;
                            load_ptr_next = load_ptr_reg + 1'b1;
                        end
                    end
                    OP_REFUSE:
                    begin
                        if (slot_free)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_FAULT;
                        end
                    end
                    OP_BITS, OP_ALIGN, OP_BYTES:
                    begin
                        if (in_words || need_fetch)
                        begin
                            mem_re = 1'b1;
                            if (in_words)
                            begin
                                scratch_next = '0;
                                fill_next    = '0;
                            end
                        end
                        else if (slot_free)
                        begin
                            emit         = 1'b1;
                            emit_value   = take_value;
                            scratch_next = take_scratch;
                            fill_next    = take_fill;
                            total_next   = take_total;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            emit = 1'b1;
                        end
                    end
                endcase
            end
            BK_WAIT:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    emit_value   = take_value;
                    scratch_next = take_scratch;
                    fill_next    = take_fill;
                    total_next   = take_total;
                end
            end
            BK_WORD:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_value = WORD_BITS'(word_byte);
                    total_next = total_reg + BITS_W'(BYTE_BITS);
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        words_next = words_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        if (mem_re)
        begin
            beyond_next   = (read_ptr_reg == PTR_W'(MAX_WORDS));
            read_ptr_next = (read_ptr_reg == PTR_W'(MAX_WORDS)) ? read_ptr_reg
                                                                : read_ptr_reg + 1'b1;
        end

        if (emit && (op_reg.kind == OP_ALIGN) && (emit_value != '0))
        begin
            emit_status = ST_PAD;
        end

        if (emit && (op_reg.kind == OP_BYTES))
        begin
            emit_last = (rem_reg == COUNT_W'(1));
            rem_next  = rem_reg - 1'b1;
            if (state_reg != BK_WORD && head_reg != 2'd0)
            begin
                head_next = head_reg - 1'b1;
            end
        end

        res_valid_next = res_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        consumed_next  = consumed_reg;
        left_next      = left_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            value_next     = emit_value;
            status_next    = emit_status;
            last_next      = emit_last;
            consumed_next  = total_next;
            left_next      = (msg_bits >= total_next) ? (msg_bits - total_next) : '0;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[load_ptr_reg[ADDR_W-1:0]] <= op_reg.word;
        end
        if (mem_re && !beyond_next)
        begin
            rd_data_reg <= mem[read_ptr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        consumed_reg <= consumed_next;
        left_reg     <= left_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            op_reg        <= '0;
            head_reg      <= '0;
            words_reg     <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            load_ptr_reg  <= '0;
            read_ptr_reg  <= '0;
            beyond_reg    <= 1'b0;
            scratch_reg   <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            words_reg     <= words_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            load_ptr_reg  <= load_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            beyond_reg    <= beyond_next;
            scratch_reg   <= scratch_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            status_reg    <= status_next;
        end
    end

    // The scratch is emptied before whole words are copied out.
    a_word_scratch_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_WORD |-> (fill_reg == '0) && (scratch_reg == '0))
        else $error("scratch not empty during a whole-word copy");

    // The front never passes a load once the store is full.
    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (load_ptr_reg < PTR_W'(MAX_WORDS)))
        else $error("word store written beyond its depth");

    // A byte run in progress always has bytes left to deliver.
    a_bytes_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC) && (op_reg.kind == OP_BYTES) |-> (rem_reg != '0))
        else $error("byte run active with no bytes remaining");

    // Every word fetch is followed by a state that consumes the read data.
    a_fetch_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == BK_WAIT) || (state_reg == BK_WORD))
        else $error("word fetched without a consuming state");

endmodule

/* rtl/bitstream_field_reader.sv */
// An accepted transaction reaches the result register through the operation queue and the
// back end's operation register, and also the store's read data register when a word must be fetched.
// The back end takes a new command from the queue only once the last one has finished.
// Read bytes delivers one byte per cycle while results are taken, apart from each word fetch.
// Reset clears the length register, pointers, scratch and counts; the word store
// holds undefined data until it is loaded.
// ============================================================================
// bitstream_field_reader
// Unpacks bit fields from a loaded message of 32-bit words, with a command
// front end, a short operation queue and an execution back end.
// ============================================================================
module bitstream_field_reader #(
    parameter int MAX_WORDS = bfr_pkg::DEF_MAX_WORDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [bfr_pkg::LEN_W-1:0]     cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [bfr_pkg::CMD_W-1:0]     cmd,
    input  logic [bfr_pkg::COUNT_W-1:0]   field_bits,
    input  logic [bfr_pkg::COUNT_W-1:0]   byte_count,
    input  logic [bfr_pkg::WORD_BITS-1:0] load_word,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [bfr_pkg::WORD_BITS-1:0] value,
    output logic [bfr_pkg::STAT_W-1:0]    status,
    output logic                          last,
    output logic [bfr_pkg::BITS_W-1:0]    bits_consumed,
    output logic [bfr_pkg::BITS_W-1:0]    bits_left
);
    import bfr_pkg::*;

    logic              queue_full;
    logic              push;
    op_t               push_op;
    logic              q_pop;
    logic              q_not_empty;
    op_t               q_op;
    logic [BITS_W-1:0] msg_bits;

    bfr_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .field_bits (field_bits),
        .byte_count (byte_count),
        .load_word  (load_word),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op),
        .msg_bits   (msg_bits)
    );

    bfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_op    (q_op)
    );

    bfr_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg_bits      (msg_bits),
        .q_not_empty   (q_not_empty),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .value         (value),
        .status        (status),
        .last          (last),
        .bits_consumed (bits_consumed),
        .bits_left     (bits_left)
    );

endmodule

/* tb/tb_bitstream_field_reader.sv */
// ============================================================================
// tb_bitstream_field_reader
// Self-checking testbench for the bitstream field reader. A queue-fed driver
// offers commands with random gaps, a monitor with random back-pressure checks
// every result transaction against an in-bench prediction of the unpacker,
// and the message length is changed between phases while the block is idle.
// ============================================================================
module tb_bitstream_field_reader;

    timeunit 1ns;
    timeprecision 1ps;

    import bfr_pkg::*;

    localparam int STORE_WORDS  = DEF_MAX_WORDS;
    localparam int IDLE_PERCENT = 23;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [CMD_W-1:0]     op;
        logic [COUNT_W-1:0]   nbits;
        logic [COUNT_W-1:0]   nbytes;
        logic [WORD_BITS-1:0] word;
    } command_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic [STAT_W-1:0]    status;
        logic                 last;
        logic [BITS_W-1:0]    consumed;
        logic [BITS_W-1:0]    left;
    } field_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wen    = 1'b0;
    logic [LEN_W-1:0]     cfg_wdata  = '0;
    logic                 cmd_valid  = 1'b0;
    logic                 cmd_ready;
    logic [CMD_W-1:0]     cmd        = '0;
    logic [COUNT_W-1:0]   field_bits = '0;
    logic [COUNT_W-1:0]   byte_count = '0;
    logic [WORD_BITS-1:0] load_word  = '0;
    logic                 res_valid;
    logic                 res_ready  = 1'b0;
    logic [WORD_BITS-1:0] value;
    logic [STAT_W-1:0]    status;
    logic                 last;
    logic [BITS_W-1:0]    bits_consumed;
    logic [BITS_W-1:0]    bits_left;

    command_t      pending_commands[$];
    field_result_t results_due[$];
    command_t      offered;
    int unsigned   failures        = 0;
    bit            steady_flow     = 1'b0;
    bit            start_long_hold = 1'b0;
    bit            long_hold_done  = 1'b0;
    int unsigned   hold_left       = 0;

    logic [WORD_BITS-1:0] word_mem [STORE_WORDS];
    int unsigned          load_ptr     = 0;
    int unsigned          rd_word_ptr  = 0;
    logic [63:0]          scratch_bits = '0;
    int unsigned          scratch_fill = 0;
    int unsigned          bits_read    = 0;
    int unsigned          msg_bytes    = 0;

    int unsigned gen_load_ptr  = 0;
    int unsigned words_written = 0;
    int unsigned items_queued  = 0;

    bitstream_field_reader i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .field_bits    (field_bits),
        .byte_count    (byte_count),
        .load_word     (load_word),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .value         (value),
        .status        (status),
        .last          (last),
        .bits_consumed (bits_consumed),
        .bits_left     (bits_left)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [WORD_BITS-1:0] fetch_message_word();
        logic [WORD_BITS-1:0] w;
        w = '0;
        if (rd_word_ptr < STORE_WORDS)
        begin
            w = word_mem[rd_word_ptr];
        end
        rd_word_ptr++;
        return w;
    endfunction

    function automatic logic [WORD_BITS-1:0] pull_bits(int unsigned n);
        logic [WORD_BITS-1:0] v;
        bits_read += n;
        if (scratch_fill < n)
        begin
            scratch_bits |= {32'd0, fetch_message_word()} << scratch_fill;
            scratch_fill += WORD_BITS;
        end
        v = WORD_BITS'(scratch_bits & ((64'd1 << n) - 64'd1));
        scratch_bits >>= n;
        scratch_fill -= n;
        return v;
    endfunction

    function automatic bit fits_message(int unsigned n);
        return bits_read + n <= msg_bytes * BYTE_BITS;
    endfunction

    function automatic void post_result(logic [WORD_BITS-1:0] v, logic [STAT_W-1:0] st,
                                        logic fin);
        field_result_t r;
        int unsigned   limit_bits;
        limit_bits = msg_bytes * BYTE_BITS;
        r.value    = v;
        r.status   = st;
        r.last     = fin;
        r.consumed = BITS_W'(bits_read);
        r.left     = (bits_read <= limit_bits) ? BITS_W'(limit_bits - bits_read) : '0;
        results_due.push_back(r);
    endfunction

    function automatic void predict_command(command_t c);
        int unsigned          pad_bits;
        int unsigned          head;
        int unsigned          whole;
        int unsigned          tail;
        int unsigned          k;
        int unsigned          j;
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] w;
        case (c.op)
            CMD_RESTART:
            begin
                load_ptr     = 0;
                rd_word_ptr  = 0;
                scratch_bits = '0;
                scratch_fill = 0;
                bits_read    = 0;
                post_result('0, ST_OK, 1'b1);
            end
            CMD_LOAD:
            begin
                if (load_ptr < STORE_WORDS)
                begin
                    word_mem[load_ptr] = c.word;
                    load_ptr++;
                    post_result('0, ST_OK, 1'b1);
                end
                else
                begin
                    post_result('0, ST_FAULT, 1'b1);
                end
            end
            CMD_READ_BITS:
            begin
                if (c.nbits == 0 || c.nbits > WORD_BITS || !fits_message(c.nbits))
                begin
                    post_result('0, ST_FAULT, 1'b1);
                end
                else
                begin
                    post_result(pull_bits(c.nbits), ST_OK, 1'b1);
                end
            end
            CMD_ALIGN:
            begin
                pad_bits = (BYTE_BITS - bits_read % BYTE_BITS) % BYTE_BITS;
                if (pad_bits == 0)
                begin
                    post_result('0, ST_OK, 1'b1);
                end
                else if (!fits_message(pad_bits))
                begin
                    post_result('0, ST_FAULT, 1'b1);
                end
                else
                begin
                    v = pull_bits(pad_bits);
                    post_result(v, (v != 0) ? ST_PAD : ST_OK, 1'b1);
                end
            end
            CMD_READ_BYTES:
            begin
                if (c.nbytes == 0 || c.nbytes > MAX_READ_BYTES || c.nbytes > RESULT_LIMIT
                    || bits_read % BYTE_BITS != 0 || !fits_message(c.nbytes * BYTE_BITS))
                begin
                    post_result('0, ST_FAULT, 1'b1);
                end
                else
                begin
                    head = (BYTES_PER_WORD - (bits_read % WORD_BITS) / BYTE_BITS)
                           % BYTES_PER_WORD;
                    if (head > c.nbytes)
                    begin
                        head = c.nbytes;
                    end
                    whole = (c.nbytes - head) / BYTES_PER_WORD;
                    tail  = c.nbytes - head - whole * BYTES_PER_WORD;
                    k     = 0;
                    repeat (head)
                    begin
                        k++;
                        post_result(pull_bits(BYTE_BITS), ST_OK, k == c.nbytes);
                    end
                    if (whole > 0)
                    begin
                        scratch_bits = '0;
                        scratch_fill = 0;
                    end
                    repeat (whole)
                    begin
                        w = fetch_message_word();
                        for (j = 0; j < BYTES_PER_WORD; j++)
                        begin
                            bits_read += BYTE_BITS;
                            k++;
                            post_result(WORD_BITS'(w[WORD_BITS-1-BYTE_BITS*j -: BYTE_BITS]),
                                        ST_OK, k == c.nbytes);
                        end
                    end
                    repeat (tail)
                    begin
                        k++;
                        post_result(pull_bits(BYTE_BITS), ST_OK, k == c.nbytes);
                    end
                end
            end
            default:
            begin
                post_result('0, ST_FAULT, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [WORD_BITS-1:0] expected,
                                        logic [WORD_BITS-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, expected, actual);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : drive_commands
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_command(offered);
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_commands.size() != 0
                    && (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    offered = pending_commands.pop_front();
                    cmd_valid  <= 1'b1;
                    cmd        <= offered.op;
                    field_bits <= offered.nbits;
                    byte_count <= offered.nbytes;
                    load_word  <= offered.word;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : receive_results
        field_result_t due;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result transaction: value 'h%0h status %0d",
                           value, status);
                    failures++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("value", due.value, value);
                    check_field("status", WORD_BITS'(due.status), WORD_BITS'(status));
                    check_field("last", WORD_BITS'(due.last), WORD_BITS'(last));
                    check_field("bits_consumed", WORD_BITS'(due.consumed),
                                WORD_BITS'(bits_consumed));
                    check_field("bits_left", WORD_BITS'(due.left), WORD_BITS'(bits_left));
                end
            end
            if (start_long_hold && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send(logic [CMD_W-1:0] op, logic [COUNT_W-1:0] nbits,
                        logic [COUNT_W-1:0] nbytes, logic [WORD_BITS-1:0] word);
        command_t c;
        c.op     = op;
        c.nbits  = nbits;
        c.nbytes = nbytes;
        c.word   = word;
        pending_commands.push_back(c);
        items_queued++;
        if (op == CMD_RESTART)
        begin
            gen_load_ptr = 0;
        end
        else if (op == CMD_LOAD && gen_load_ptr < STORE_WORDS)
        begin
            gen_load_ptr++;
            if (gen_load_ptr > words_written)
            begin
                words_written = gen_load_ptr;
            end
        end
    endtask

    task automatic wait_for_idle();
        while (pending_commands.size() != 0 || cmd_valid || results_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_length(int unsigned n);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= LEN_W'(n);
        msg_bytes = n;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    // Reads, with some loads, restarts and illegal commands, are offered until roughly the given
    // number of message bits has been asked for; most byte runs are preceded by an align so that they are accepted.
    task automatic queue_reads(int unsigned budget, bit heavy);
        int unsigned spent;
        int unsigned pick;
        int unsigned n;
        spent = 0;
        while (spent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
            begin
                n = ($urandom_range(19) == 0) ? $urandom_range(63)
                                              : $urandom_range(1, WORD_BITS);
                send(CMD_READ_BITS, COUNT_W'(n), COUNT_W'($urandom), $urandom);
                spent += n;
            end
            else if (pick < 52)
            begin
                send(CMD_ALIGN, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
                spent += 4;
            end
            else if (pick < 92)
            begin
                if (pick < 85)
                begin
                    send(CMD_ALIGN, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
                    spent += 4;
                end
                if (heavy && $urandom_range(4) != 0)
                    n = MAX_READ_BYTES;
                else if ($urandom_range(15) == 0)
                    n = $urandom_range(63);
                else if ($urandom_range(4) == 0)
                    n = $urandom_range(1, MAX_READ_BYTES);
                else
                    n = $urandom_range(1, 12);
                send(CMD_READ_BYTES, COUNT_W'($urandom), COUNT_W'(n), $urandom);
                spent += n * BYTE_BITS;
            end
            else if (pick < 96)
            begin
                send(CMD_W'(CMD_READ_BYTES) + CMD_W'($urandom_range(1, 3)),
                     COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
                spent += 2;
            end
            else if (pick < 98 || heavy)
            begin
                send(CMD_LOAD, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
                spent += 2;
            end
            else
            begin
                send(CMD_RESTART, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
                spent += 2;
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned loads;
        int unsigned pick;
        int unsigned length;
        int unsigned k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(CMD_READ_BITS, COUNT_W'(8), COUNT_W'($urandom), $urandom);
        for (k = 1; k <= 3; k++)
        begin
            send(CMD_W'(CMD_READ_BYTES) + CMD_W'(k), '1, '1, '1);
        end
        send(CMD_LOAD, '0, '0, 32'hFFFF_FFFF);
        send(CMD_LOAD, '1, '1, 32'h0000_0000);
        send(CMD_LOAD, '0, '1, 32'h1234_5678);
        send(CMD_LOAD, '1, '0, 32'h89AB_CDEF);
        wait_for_idle();
        write_length(16);

        send(CMD_READ_BITS, COUNT_W'(0), '1, '1);
        send(CMD_READ_BITS, COUNT_W'(63), '0, '0);
        send(CMD_READ_BYTES, '1, COUNT_W'(0), '1);
        send(CMD_READ_BYTES, '0, COUNT_W'(63), '0);
        send(CMD_READ_BITS, COUNT_W'(1), '0, '0);
        send(CMD_READ_BITS, COUNT_W'(3), '0, '0);
        send(CMD_READ_BYTES, '0, COUNT_W'(2), '0);
        send(CMD_ALIGN, '0, '0, '0);
        send(CMD_READ_BITS, COUNT_W'(32), '0, '0);
        send(CMD_READ_BITS, COUNT_W'(4), '0, '0);
        send(CMD_ALIGN, '1, '1, '1);
        send(CMD_ALIGN, '0, '0, '0);
        send(CMD_READ_BYTES, '0, COUNT_W'(9), '0);
        send(CMD_READ_BITS, COUNT_W'(32), '0, '0);
        send(CMD_READ_BITS, COUNT_W'(8), '0, '0);
        send(CMD_READ_BITS, COUNT_W'(1), '0, '0);
        wait_for_idle();

        // The length now drops below what has already been read.
        write_length(0);
        send(CMD_READ_BITS, COUNT_W'(1), '0, '0);
        send(CMD_RESTART, '1, '1, '1);
        send(CMD_READ_BYTES, '0, COUNT_W'(1), '0);
        wait_for_idle();

        phase = 0;
        while (items_queued < 185)
        begin
            steady_flow = 1'b0;
            if (phase == 0 || $urandom_range(3) != 0)
            begin
                send(CMD_RESTART, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
            end
            loads = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12);
            repeat (loads)
            begin
                send(CMD_LOAD, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
            end
            wait_for_idle();
            pick = $urandom_range(9);
            if (pick < 4)
                length = words_written * BYTES_PER_WORD;
            else if (pick < 9)
                length = $urandom_range(words_written * BYTES_PER_WORD);
            else
                length = 0;
            write_length(length);
            steady_flow = (phase == 2);
            queue_reads(((length * BYTE_BITS > 600) ? 600 : length * BYTE_BITS) + 40, 1'b0);
            wait_for_idle();
            phase++;
        end
        steady_flow = 1'b0;

        // Load a fresh message and read long byte runs while the receiver holds off.
        send(CMD_RESTART, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
        repeat (16)
        begin
            send(CMD_LOAD, COUNT_W'($urandom), COUNT_W'($urandom), $urandom);
        end
        wait_for_idle();
        write_length(words_written * BYTES_PER_WORD);
        start_long_hold = 1'b1;
        queue_reads(700, 1'b1);
        wait_for_idle();

        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("bitstream_field_reader regression: pass");
        end
        else
        begin
            $display("bitstream_field_reader regression: fail");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("bitstream_field_reader regression: fail");
        $finish;
    end

endmodule
